// File: hdl/spim_pkg.sv
// Shared types and constants of the SPI master.
package spim_pkg;

    localparam int DEF_MAX_WORD_BITS = 16;
    localparam int DEF_DIVIDER_BITS  = 7;

    // Width of the stored half-period divider field
    localparam int DIV_FIELD_BITS = 7;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [1:0] {
        FUNC_TICK        = 2'd0,
        FUNC_WRITE_DATA  = 2'd1,
        FUNC_READ_DATA   = 2'd2,
        FUNC_READ_STATUS = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_SPI_ENABLE   = 3'd0,
        REG_WORD_IS_16   = 3'd1,
        REG_CLOCK_POL    = 3'd2,
        REG_CLOCK_PHASE  = 3'd3,
        REG_HALF_DIV     = 3'd4,
        REG_RX_IRQ_EN    = 3'd5,
        REG_TX_IRQ_EN    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] write_data;
        logic        miso_in;
    } t_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic        busy_flag;
        logic        rx_full_flag;
        logic        sclk_out;
        logic        mosi_out;
        logic        irq_out;
    } t_rsp;

    // Static control bits
    typedef struct packed {
        logic spi_enable;
        logic word_is_16;
        logic clock_polarity;
        logic clock_phase;
        logic rx_irq_enable;
        logic tx_irq_enable;
    } t_cfg;

    // Register writes that touch the shifter state
    typedef struct packed {
        logic disable_wr;
        logic pol_wr;
        logic pol_val;
    } t_cfg_evt;

endpackage

// File: hdl/spim_if.sv
// Request and response channel interfaces of the SPI master.
interface spim_req_if;
    import spim_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface spim_rsp_if;
    import spim_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/spim_regs.sv
// APB configuration registers of the SPI master.
module spim_regs #(
    parameter int DIVIDER_BITS = spim_pkg::DEF_DIVIDER_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spim_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [spim_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [spim_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output spim_pkg::t_cfg                      o_cfg,
    output spim_pkg::t_cfg_evt                  o_evt,
    output logic [DIVIDER_BITS-1:0]             o_div
);
    import spim_pkg::*;

    localparam int KEEP = (DIVIDER_BITS < DIV_FIELD_BITS) ? DIVIDER_BITS : DIV_FIELD_BITS;

    t_cfg                    r_cfg;
    logic [DIVIDER_BITS-1:0] r_div;
    logic                    wr_en;
    t_reg_idx                idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_div <= DIVIDER_BITS'(1);
        end else if (wr_en) begin
            case (idx)
                REG_SPI_ENABLE:  r_cfg.spi_enable     <= pwdata[0];
                REG_WORD_IS_16:  r_cfg.word_is_16     <= pwdata[0];
                REG_CLOCK_POL:   r_cfg.clock_polarity <= pwdata[0];
                REG_CLOCK_PHASE: r_cfg.clock_phase    <= pwdata[0];
                REG_HALF_DIV:    r_div <= DIVIDER_BITS'(pwdata[KEEP-1:0]);
                REG_RX_IRQ_EN:   r_cfg.rx_irq_enable  <= pwdata[0];
                REG_TX_IRQ_EN:   r_cfg.tx_irq_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_evt.disable_wr = wr_en && (idx == REG_SPI_ENABLE) && !pwdata[0];
        o_evt.pol_wr     = wr_en && (idx == REG_CLOCK_POL);
        o_evt.pol_val    = pwdata[0];
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_SPI_ENABLE:  prdata[0] = r_cfg.spi_enable;
            REG_WORD_IS_16:  prdata[0] = r_cfg.word_is_16;
            REG_CLOCK_POL:   prdata[0] = r_cfg.clock_polarity;
            REG_CLOCK_PHASE: prdata[0] = r_cfg.clock_phase;
            REG_HALF_DIV:    prdata = APB_DATA_BITS'(r_div);
            REG_RX_IRQ_EN:   prdata[0] = r_cfg.rx_irq_enable;
            REG_TX_IRQ_EN:   prdata[0] = r_cfg.tx_irq_enable;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
    assign o_div = r_div;

endmodule

// File: hdl/spi_master_8_16_bit.sv
// Top level of the SPI master: shifter state, request handling, response register.
//
// Each request is one bus access: a divider tick, a data write, a data read or a
// status read. A request is taken every clock cycle while the response register is
// empty or being drained; its response (read data, busy, receive-full, clock and
// data pin levels, interrupt) appears in the response register the next cycle,
// so throughput is one request per cycle. The only thing
// that holds the request side is a full response register that the sink does not
// take. The serial clock toggles after half_period_divider+1 tick requests; words
// shift MSB first, 8 bits or 16 bits (capped at MAX_WORD_BITS), the length latched
// when the data write loads the word. Sampling follows clock_phase: phase 0 samples
// on the leading edge, phase 1 on the trailing edge. A finished word overwrites the
// receive buffer and sets receive-full; a data read clears it. Configuration sits on
// the APB port at byte address 4*index and must only be written while no request is
// outstanding. Writing spi_enable to zero aborts a word in flight.
module spi_master_8_16_bit #(
    parameter int MAX_WORD_BITS = spim_pkg::DEF_MAX_WORD_BITS,
    parameter int DIVIDER_BITS  = spim_pkg::DEF_DIVIDER_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    spim_req_if.sink                            i_req,
    spim_rsp_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spim_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [spim_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [spim_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import spim_pkg::*;

    localparam int MW    = MAX_WORD_BITS;
    localparam int LEN16 = (MW < 16) ? MW : 16;    // length of a "16-bit" word
    localparam int BLW   = $clog2(MW + 1);         // bits_left counter width
    localparam int HW    = (MW < 16) ? MW : 16;    // bits moved to the rx buffer

    localparam logic [MW-1:0] MASK8  = {MW{1'b1}} >> (MW - 8);
    localparam logic [MW-1:0] MASK16 = {MW{1'b1}} >> (MW - LEN16);

    t_cfg                    cfg;
    t_cfg_evt                evt;
    logic [DIVIDER_BITS-1:0] div;

    spim_regs #(
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_evt   (evt),
        .o_div   (div)
    );

    // Shifter state
    logic [MW-1:0]           r_tx,   n_tx;
    logic [MW-1:0]           r_rx,   n_rx;
    logic [15:0]             r_hold, n_hold;
    logic [BLW-1:0]          r_bl,   n_bl;
    logic [DIVIDER_BITS-1:0] r_hc,   n_hc;
    logic                    r_lvl,  n_lvl;
    logic                    r_busy, n_busy;
    logic                    r_rxf,  n_rxf;
    logic                    r_len16, n_len16;

    // Response register
    logic r_out_valid;
    t_rsp r_rsp, n_rsp;

    logic           accept;
    t_req           req;
    logic [MW-1:0]  len_mask;
    logic [BLW-1:0] len_val;
    logic           leading;
    logic           do_sample;
    logic           do_shift;
    logic           do_finish;
    logic [BLW-1:0] bl_after;
    logic [MW-1:0]  rx_after;
    logic [MW-1:0]  wdata_ext;
    logic           mosi_bit;

    assign req          = i_req.payload;
    assign i_req.ready  = !r_out_valid || o_rsp.ready;
    assign accept       = i_req.valid && i_req.ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_hold  = r_hold;
        n_bl    = r_bl;
        n_hc    = r_hc;
        n_lvl   = r_lvl;
        n_busy  = r_busy;
        n_rxf   = r_rxf;
        n_len16 = r_len16;

        len_mask  = r_len16 ? MASK16 : MASK8;
        len_val   = r_len16 ? BLW'(LEN16) : BLW'(8);
        leading   = 1'b0;
        do_sample = 1'b0;
        do_shift  = 1'b0;
        do_finish = 1'b0;
        bl_after  = r_bl;
        rx_after  = r_rx;
        wdata_ext = MW'(req.write_data);

        n_rsp           = '0;

        if (accept) begin
            case (t_func'(req.func))
                FUNC_TICK: begin
                    if (cfg.spi_enable && r_busy) begin
                        if (r_hc < div) begin
                            n_hc = r_hc + DIVIDER_BITS'(1);
                        end else begin
                            // serial clock edge
                            n_hc    = '0;
                            n_lvl   = !r_lvl;
                            leading = (!r_lvl) != cfg.clock_polarity;
                            if (!cfg.clock_phase) begin
                                do_sample = leading;
                                do_shift  = !leading;
                            end else begin
                                do_sample = !leading;
                                do_shift  = leading && (r_bl != len_val);
                            end
                            if (do_sample) begin
                                rx_after = ((r_rx << 1) | MW'(req.miso_in)) & len_mask;
                                if (r_bl != '0) begin
                                    bl_after = r_bl - BLW'(1);
                                end
                            end
                            n_rx = rx_after;
                            n_bl = bl_after;
                            if (do_shift) begin
                                n_tx = (r_tx << 1) & len_mask;
                            end
                            do_finish = !leading && (bl_after == '0);
                            if (do_finish) begin
                                n_hold = 16'(rx_after[HW-1:0]);
                                n_rxf  = 1'b1;
                                n_busy = 1'b0;
                                n_hc   = '0;
                                n_lvl  = cfg.clock_polarity;
                            end
                        end
                    end
                end
                FUNC_WRITE_DATA: begin
                    if (cfg.spi_enable && !r_busy) begin
                        n_len16 = cfg.word_is_16;
                        n_tx    = wdata_ext & (cfg.word_is_16 ? MASK16 : MASK8);
                        n_rx    = '0;
                        n_bl    = cfg.word_is_16 ? BLW'(LEN16) : BLW'(8);
                        n_hc    = '0;
                        n_lvl   = cfg.clock_polarity;
                        n_busy  = 1'b1;
                    end
                end
                FUNC_READ_DATA: begin
                    n_rsp.read_data = r_hold;
                    n_rxf           = 1'b0;
                end
                default: ;
            endcase
        end

        // Register writes that act on the shifter
        if (evt.disable_wr) begin
            n_busy = 1'b0;
            n_hc   = '0;
            n_lvl  = cfg.clock_polarity;
        end
        if (evt.pol_wr && !n_busy) begin
            n_lvl = evt.pol_val;
        end

        mosi_bit           = n_len16 ? n_tx[LEN16-1] : n_tx[7];
        n_rsp.busy_flag    = n_busy;
        n_rsp.rx_full_flag = n_rxf;
        n_rsp.sclk_out     = n_busy ? n_lvl : cfg.clock_polarity;
        n_rsp.mosi_out     = n_busy & mosi_bit;
        n_rsp.irq_out      = (cfg.rx_irq_enable & n_rxf) |
                             (cfg.tx_irq_enable & cfg.spi_enable & !n_busy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx        <= '0;
            r_rx        <= '0;
            r_hold      <= '0;
            r_bl        <= '0;
            r_hc        <= '0;
            r_lvl       <= 1'b0;
            r_busy      <= 1'b0;
            r_rxf       <= 1'b0;
            r_len16     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_hold  <= n_hold;
            r_bl    <= n_bl;
            r_hc    <= n_hc;
            r_lvl   <= n_lvl;
            r_busy  <= n_busy;
            r_rxf   <= n_rxf;
            r_len16 <= n_len16;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload, loaded on each accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
